FILE: rtl/mmm_pkg.sv
// shared types and constants of the multichannel moving median unit
package mmm_pkg;

    localparam int CH_W     = 5;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // sequencer to rank unit
    typedef struct packed {
        logic cand_load;
        logic cmp_en;
    } rank_ctrl_t;

    // rank unit to sequencer
    typedef struct packed {
        logic    found;
        sample_t value;
    } rank_stat_t;

endpackage

FILE: rtl/mmm_in_if.sv
// input item channel: channel number and sample
interface mmm_in_if import mmm_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] channel;
    sample_t         sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

FILE: rtl/mmm_out_if.sv
// result item channel: median and out-of-range flag
interface mmm_out_if import mmm_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t median;
    logic    out_of_range;

    modport source (output valid, output median, output out_of_range, input ready);
    modport sink (input valid, input median, input out_of_range, output ready);
endinterface

FILE: rtl/mmm_rank.sv
// shared compare unit with less-than and less-or-equal counters for rank selection
module mmm_rank import mmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rank_ctrl_t       ctrl,
    input  sample_t          rd_data,
    input  logic [LEN_W-1:0] rank,
    output rank_stat_t       stat
);

    sample_t          cand_reg;
    logic [LEN_W-1:0] lt_cnt_reg;
    logic [LEN_W-1:0] le_cnt_reg;
    logic [LEN_W-1:0] lt_cnt_next;
    logic [LEN_W-1:0] le_cnt_next;
    logic             is_lt;
    logic             is_le;

    assign is_lt = rd_data < cand_reg;
    assign is_le = is_lt || (rd_data == cand_reg);

    always_comb
    begin
        priority if (ctrl.cand_load)
        begin
            lt_cnt_next = '0;
            le_cnt_next = '0;
        end
        else if (ctrl.cmp_en)
        begin
            lt_cnt_next = lt_cnt_reg + LEN_W'(is_lt);
            le_cnt_next = le_cnt_reg + LEN_W'(is_le);
        end
        else
        begin
            lt_cnt_next = lt_cnt_reg;
            le_cnt_next = le_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_cnt_reg <= '0;
            le_cnt_reg <= '0;
        end
        else
        begin
            lt_cnt_reg <= lt_cnt_next;
            le_cnt_reg <= le_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cand_load)
        begin
            cand_reg <= rd_data;
        end
    end

    // candidate holds the requested rank when rank falls in [less, less-or-equal)
    assign stat.found = (lt_cnt_reg <= rank) && (rank < le_cnt_reg);
    assign stat.value = cand_reg;

endmodule

FILE: rtl/multichannel_moving_median_unit.sv
// Multichannel moving median: each channel keeps a circular window of samples in one
// shared sample memory of CHANNELS*MAX_WINDOW entries. After reset a clearing pass writes
// zero to every entry, one per cycle, and no item is accepted until it ends; window_length
// writes are taken at any time. An item with a channel at or above CHANNELS, or taken
// while window_length is zero or not below MAX_WINDOW, gives its result in the cycle after
// it is accepted. Any other item is written into its channel's window and then ranked by
// testing candidates in slot order, each with one memory read per slot through the single
// read port and one compare unit, until a candidate is found that holds the median; the
// result then waits for the output to be free. One item is handled at a time.
module multichannel_moving_median_unit import mmm_pkg::*;
#(
    parameter int CHANNELS   = 20,
    parameter int MAX_WINDOW = 50
)
(
    input  logic             clk,
    input  logic             rst_n,
    mmm_in_if.sink           sample_in,
    mmm_out_if.source        result_out,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    localparam int DEPTH    = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W    = $clog2(MAX_WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_CAND_RD = 3'd3;
    localparam logic [2:0] S_CAND_LD = 3'd4;
    localparam logic [2:0] S_SCAN    = 3'd5;
    localparam logic [2:0] S_DECIDE  = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [PTR_W-1:0]  wp_reg [CHANNELS];
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    sample_t           samp_reg, samp_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cand_idx_reg, cand_idx_next;
    logic [LEN_W-1:0]  scan_reg, scan_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [LEN_W-1:0]  window_length_reg;
    logic              out_valid_reg, out_valid_next;
    sample_t           median_reg, median_next;
    logic              oor_reg, oor_next;

    sample_t           mem [DEPTH];
    sample_t           rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    sample_t           mem_wdata;
    logic [LEN_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] mem_raddr;

    logic                in_fire;
    logic                out_free;
    logic                ch_ok;
    logic                len_ok;
    logic [CH_IDX_W-1:0] ch_idx;
    logic [PTR_W:0]      ptr_inc;
    logic [PTR_W-1:0]    ptr_new;
    logic                wp_we;

    rank_ctrl_t rank_ctrl;
    rank_stat_t rank_stat;

    assign out_free        = !out_valid_reg || result_out.ready;
    assign sample_in.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire         = sample_in.valid && sample_in.ready;

    assign ch_ok  = 32'(sample_in.channel) < CHANNELS;
    assign len_ok = (window_length_reg != '0) && (32'(window_length_reg) < MAX_WINDOW);
    assign ch_idx = sample_in.channel[CH_IDX_W-1:0];

    // advance the pointer first, wrap when it reaches the window length
    assign ptr_inc = {1'b0, wp_reg[ch_idx]} + (PTR_W+1)'(1);
    assign ptr_new = ((LEN_W+1)'(ptr_inc) >= (LEN_W+1)'(window_length_reg))
                     ? '0 : ptr_inc[PTR_W-1:0];

    assign mem_raddr = base_reg + ADDR_W'(rd_idx);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        base_next      = base_reg;
        ptr_next       = ptr_reg;
        samp_next      = samp_reg;
        len_next       = len_reg;
        cand_idx_next  = cand_idx_reg;
        scan_next      = scan_reg;
        cmp_valid_next = 1'b0;
        out_valid_next = out_valid_reg && !result_out.ready;
        median_next    = median_reg;
        oor_next       = oor_reg;
        mem_we         = 1'b0;
        mem_waddr      = base_reg + ADDR_W'(ptr_reg);
        mem_wdata      = samp_reg;
        rd_idx         = scan_reg;
        wp_we          = 1'b0;
        rank_ctrl      = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (!ch_ok)
                    begin
                        out_valid_next = 1'b1;
                        median_next    = '0;
                        oor_next       = 1'b1;
                    end
                    else if (!len_ok)
                    begin
                        out_valid_next = 1'b1;
                        median_next    = '0;
                        oor_next       = 1'b0;
                    end
                    else
                    begin
                        wp_we      = 1'b1;
                        base_next  = ADDR_W'(32'(sample_in.channel) * MAX_WINDOW);
                        ptr_next   = ptr_new;
                        samp_next  = sample_in.sample;
                        len_next   = window_length_reg;
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                mem_we        = 1'b1;
                cand_idx_next = '0;
                state_next    = S_CAND_RD;
            end
            S_CAND_RD:
            begin
                rd_idx     = cand_idx_reg;
                state_next = S_CAND_LD;
            end
            S_CAND_LD:
            begin
                rank_ctrl.cand_load = 1'b1;
                scan_next           = '0;
                state_next          = S_SCAN;
            end
            S_SCAN:
            begin
                // read slot scan_reg now, compare it in the next cycle
                rd_idx           = scan_reg;
                rank_ctrl.cmp_en = cmp_valid_reg;
                if (scan_reg < len_reg)
                begin
                    scan_next      = scan_reg + LEN_W'(1);
                    cmp_valid_next = 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (rank_stat.found)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + LEN_W'(1);
                    state_next    = S_CAND_RD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    median_next    = rank_stat.value;
                    oor_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_addr_reg      <= '0;
            cmp_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            window_length_reg <= LEN_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
            end
            if (wp_we)
            begin
                wp_reg[ch_idx] <= ptr_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        ptr_reg      <= ptr_next;
        samp_reg     <= samp_next;
        len_reg      <= len_next;
        cand_idx_reg <= cand_idx_next;
        scan_reg     <= scan_next;
        median_reg   <= median_next;
        oor_reg      <= oor_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    mmm_rank u_rank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rank_ctrl),
        .rd_data (rd_data_reg),
        .rank    (len_reg >> 1),
        .stat    (rank_stat)
    );

    assign result_out.valid        = out_valid_reg;
    assign result_out.median       = median_reg;
    assign result_out.out_of_range = oor_reg;

endmodule

FILE: rtl/mmm_checker.sv
// port-level checks of the multichannel moving median unit and their bind
module mmm_checker import mmm_pkg::*;
#(
    parameter int CHANNELS = 20
)
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic [CH_W-1:0] in_channel,
    input logic            out_valid,
    input logic            out_ready,
    input sample_t         out_median,
    input logic            out_oor
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_median) && $stable(out_oor))
        else $error("result item changed while stalled");

    // a bad channel answers at once with zero and the flag
    a_oor_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (32'(in_channel) >= CHANNELS)
        |=> out_valid && out_oor && (out_median == '0))
        else $error("out-of-range item not answered next cycle");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_oor |-> out_median == '0)
        else $error("out-of-range result carries a nonzero median");

    // no new item while a result is still blocked
    a_no_take_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result item blocked");

endmodule

bind multichannel_moving_median_unit mmm_checker #(.CHANNELS(CHANNELS)) u_mmm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_in.valid),
    .in_ready   (sample_in.ready),
    .in_channel (sample_in.channel),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_median (result_out.median),
    .out_oor    (result_out.out_of_range)
);

FILE: dv/testbench.sv
// testbench for the multichannel moving median unit with self-checking scoreboard
`timescale 1ns / 1ps

module testbench import mmm_pkg::*;;

    localparam int CHANNELS   = 20;
    localparam int MAX_WINDOW = 50;

    typedef struct {
        sample_t median;
        logic    out_of_range;
    } median_result_t;

    class median_scoreboard;
        sample_t          slots[CHANNELS][MAX_WINDOW];
        int               wr_ptr[CHANNELS];
        logic [LEN_W-1:0] win_len;
        median_result_t   medians_due[$];
        int               errors;

        function new();
            foreach (slots[c, i])
                slots[c][i] = '0;
            foreach (wr_ptr[c])
                wr_ptr[c] = 0;
            win_len = LEN_RESET;
            errors  = 0;
        endfunction

        function int pending();
            return medians_due.size();
        endfunction

        // queues the result this sample should give, ranking the channel window for a usable length
        function void note_sample(logic [CH_W-1:0] ch, sample_t s);
            median_result_t r;
            sample_t        ranked[MAX_WINDOW];
            sample_t        v;
            int             p;
            int             j;
            r.median       = '0;
            r.out_of_range = 1'b0;
            if (ch >= CHANNELS)
                r.out_of_range = 1'b1;
            else if (win_len != 0 && win_len < MAX_WINDOW)
            begin
                p = wr_ptr[ch] + 1;
                if (p >= win_len)
                    p = 0;
                wr_ptr[ch]   = p;
                slots[ch][p] = s;
                for (int i = 0; i < win_len; i++)
                begin
                    v = slots[ch][i];
                    j = i;
                    while (j > 0 && ranked[j-1] > v)
                    begin
                        ranked[j] = ranked[j-1];
                        j--;
                    end
                    ranked[j] = v;
                end
                r.median = ranked[win_len / 2];
            end
            medians_due.push_back(r);
        endfunction

        function void check_result(sample_t med, logic oor);
            median_result_t want;
            if (medians_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: median %0d out_of_range %b", med, oor);
                return;
            end
            want = medians_due.pop_front();
            if (want.median !== med || want.out_of_range !== oor)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected median %0d oor %b, got median %0d oor %b",
                             want.median, want.out_of_range, med, oor);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;
    logic             steady;

    mmm_in_if  sample_in_bus ();
    mmm_out_if result_bus ();

    median_scoreboard sb = new();

    multichannel_moving_median_unit #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.median, result_bus.out_of_range);
    end

    // result side backpressure: open stretches mostly short, some long; short stalls, a few long ones
    initial
    begin
        int r;
        result_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            result_bus.ready <= 1'b1;
            if (r < 15)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
            result_bus.ready <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 85)
                repeat ($urandom_range(1, 3)) @(posedge clk);
            else
                repeat ($urandom_range(15, 60)) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(logic [CH_W-1:0] ch, sample_t s);
        int gap;
        gap = pick_gap();
        sample_in_bus.valid   <= 1'b1;
        sample_in_bus.channel <= ch;
        sample_in_bus.sample  <= s;
        do
            @(posedge clk);
        while (!sample_in_bus.ready);
        sb.note_sample(ch, s);
        if (gap > 0)
        begin
            sample_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        sample_in_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_window_length(logic [LEN_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        sb.win_len  = v;
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return CH_W'($urandom_range(0, 3));
        else if (r < 85)
            return CH_W'($urandom_range(0, CHANNELS - 1));
        return CH_W'($urandom_range(0, 31));
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return sample_t'($urandom_range(0, 65535));
        else if (r < 80)
            return sample_t'($urandom_range(0, 8)) - sample_t'(4);
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    initial
    begin
        int               sent;
        int               n;
        int               r;
        logic [LEN_W-1:0] len;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        steady                <= 1'b0;
        sample_in_bus.valid   <= 1'b0;
        sample_in_bus.channel <= '0;
        sample_in_bus.sample  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset window length, sample extremes, pointer wrap, last and bad channels
        send_sample(0, 16'sh7fff);
        send_sample(0, 16'sh8000);
        send_sample(0, 16'sh7fff);
        send_sample(0, 16'sh7fff);
        send_sample(0, -16'sd1);
        send_sample(CH_W'(CHANNELS - 1), 16'sd1234);
        send_sample(CH_W'(CHANNELS), 16'sd555);
        send_sample(31, -16'sd1);

        // single-entry window: median is the sample itself
        write_window_length(1);
        send_sample(3, -16'sd7);
        send_sample(3, 16'sh7fff);

        // unusable lengths give zero and leave state alone; channel check wins
        write_window_length(0);
        send_sample(1, 16'sd100);
        send_sample(25, 16'sd1);
        write_window_length(LEN_W'(MAX_WINDOW));
        send_sample(2, 16'sd5);
        write_window_length('1);
        send_sample(2, -16'sd5);

        // longest window, then shrink it under the pointer
        write_window_length(LEN_W'(MAX_WINDOW - 1));
        send_sample(4, 16'sd300);
        send_sample(4, -16'sd300);
        send_sample(4, 16'sd301);
        write_window_length(2);
        send_sample(4, 16'sd9);
        send_sample(4, -16'sd9);

        // stale slots past the shortened length stay out of the ranking
        write_window_length(3);
        send_sample(0, 16'sd10);
        send_sample(0, -16'sd10);

        sent = 0;
        while (sent < 400)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = LEN_W'($urandom_range(1, 17));
            else if (r < 82)
                len = LEN_W'($urandom_range(18, MAX_WINDOW - 1));
            else if (r < 88)
                len = LEN_W'(MAX_WINDOW - 1);
            else if (r < 92)
                len = 1;
            else
                len = LEN_W'($urandom_range(0, 1) ? $urandom_range(MAX_WINDOW, 63) : 0);
            write_window_length(len);
            if (len == 0 || len >= MAX_WINDOW)
                n = $urandom_range(4, 8);
            else if (len >= 18)
                n = $urandom_range(8, 14);
            else
                n = $urandom_range(15, 30);
            steady <= ($urandom_range(0, 4) == 0);
            repeat (n)
            begin
                send_sample(pick_channel(), pick_sample());
                sent++;
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
